// File: design/clef_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the character LCD expander formatter.
// Depends on nothing; every other file but clef_channels refers to it by scoped names.
package clef_pkg;

    // Request codes.
    localparam logic [2:0] OP_COMMAND   = 3'd0;
    localparam logic [2:0] OP_DATA      = 3'd1;
    localparam logic [2:0] OP_HEX       = 3'd2;
    localparam logic [2:0] OP_DECIMAL   = 3'd3;
    localparam logic [2:0] OP_BACKLIGHT = 3'd4;

    // Expander control bits.
    localparam logic [3:0] CTRL_RS = 4'h1;
    localparam logic [3:0] CTRL_EN = 4'h4;
    localparam logic [3:0] CTRL_BL = 4'h8;

    // ASCII '0', and '@' less nine for the letters of a hex digit.
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_HEX_BASE = 8'h37;

    localparam logic [2:0] COUNT_CHAR = 3'd7;
    localparam logic [2:0] COUNT_BL   = 3'd1;

    // A 32-bit binary value needs ten decimal digits.
    localparam int BIN_WIDTH  = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_WIDTH  = 4 * BCD_DIGITS;

    typedef struct packed {
        logic busy;
        logic done;
    } bcd_status_t;

    typedef struct packed {
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [7:0] b7;
        logic [3:0] ctrl;
    } char_frame_t;

    // Seven expander bytes for one character in 4-bit mode, and the control
    // bits left behind afterwards.
    function automatic char_frame_t char_frame(input logic [3:0] ctrl,
                                               input logic       is_data,
                                               input logic [7:0] ch);
        logic [3:0]  c1;
        logic [3:0]  c2;
        logic [3:0]  c3;
        char_frame_t f;
        c1     = {ctrl[3:1], is_data};
        c2     = c1 | CTRL_EN;
        c3     = c1 & ~CTRL_EN;
        f.b1   = {4'h0, c1};
        f.b2   = {4'h0, c2};
        f.b3   = {ch[7:4], c2};
        f.b4   = {4'h0, c3};
        f.b5   = {4'h0, c2};
        f.b6   = {ch[3:0], c2};
        f.b7   = {4'h0, c3};
        f.ctrl = c3;
        return f;
    endfunction

endpackage

// File: design/clef_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and for expander results.
// Depends on nothing but the field widths fixed by the block.
interface clef_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface clef_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [7:0] byte_fourth;
    logic [7:0] byte_fifth;
    logic [7:0] byte_sixth;
    logic [7:0] byte_seventh;
    logic [2:0] byte_count;
    logic       last_of_run;
    logic [7:0] device_address;

    modport source (output valid, output byte_first, output byte_second,
                    output byte_third, output byte_fourth, output byte_fifth,
                    output byte_sixth, output byte_seventh, output byte_count,
                    output last_of_run, output device_address, input ready);
    modport sink   (input valid, input byte_first, input byte_second,
                    input byte_third, input byte_fourth, input byte_fifth,
                    input byte_sixth, input byte_seventh, input byte_count,
                    input last_of_run, input device_address, output ready);
endinterface

// File: design/clef_bcd_conv.sv
`timescale 1ns / 1ps
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on clef_pkg for widths and the status struct.
module clef_bcd_conv
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [clef_pkg::BIN_WIDTH-1:0]    value,
    output clef_pkg::bcd_status_t             status,
    output logic [clef_pkg::BCD_WIDTH-1:0]    bcd
);

    localparam int CNT_W = $clog2(clef_pkg::BIN_WIDTH + 1);

    logic [clef_pkg::BIN_WIDTH-1:0] bin_reg;
    logic [clef_pkg::BIN_WIDTH-1:0] bin_next;
    logic [clef_pkg::BCD_WIDTH-1:0] bcd_reg;
    logic [clef_pkg::BCD_WIDTH-1:0] bcd_next;
    logic [clef_pkg::BCD_WIDTH-1:0] bcd_adj;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               cnt_next;
    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;

    // Every digit that has reached five gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < clef_pkg::BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                            : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = CNT_W'(clef_pkg::BIN_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[clef_pkg::BCD_WIDTH-2:0], bin_reg[clef_pkg::BIN_WIDTH-1]};
            bin_next = {bin_reg[clef_pkg::BIN_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

endmodule

// File: design/char_lcd_expander_formatter.sv
`timescale 1ns / 1ps
// Top level of the character LCD expander formatter: request decode, digit
// sequencing and the result register. Depends on clef_pkg, clef_channels and
// clef_bcd_conv.
//
// Usage. A request beat on the request channel carries an operation and a
// 32-bit value: command byte, data character, hex print, decimal print or
// backlight on. Each printed character leaves as one result beat of seven
// expander bytes (byte_count 7); backlight on gives one beat with one byte.
// The final beat of a request has last_of_run set. Codes five to seven are
// accepted and dropped. The configured device address travels on every
// result beat for the bus master.
// A request is taken only while the block is idle. Command, character and
// backlight requests pass through their own state and then the result
// register. A hex print gives HEX_DIGITS beats, one per cycle while the receiver
// keeps up. A decimal print waits for the bit-serial converter, then steps over
// each digit position it skips, one at a time, and then prints the remaining
// digits, one beat each. Reset clears the control bits (RS, EN, backlight),
// empties the result register and restores the device address to 0x4E. When
// the receiver stalls, the result register holds its beat and the sequencer
// waits with it.
module char_lcd_expander_formatter
#(
    parameter int DEC_DIGITS = 10,
    parameter int HEX_DIGITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    clef_req_if.sink    request,
    clef_res_if.source  result,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data
);

    // Hex digits above bit 31 print as zero; fewer than eight digits drop the
    // top of the value, so the value is shifted up on load.
    localparam int HEX_CW  = (HEX_DIGITS > 1) ? $clog2(HEX_DIGITS) : 1;
    localparam int HEX_PRE = (HEX_DIGITS < 8) ? 4 * (8 - HEX_DIGITS) : 0;
    localparam logic [HEX_CW-1:0] HEX_TOP  = HEX_CW'(HEX_DIGITS - 1);
    localparam logic [4:0]        DEC_KEEP = 5'(DEC_DIGITS);
    localparam logic [3:0]        DIG_TOP  = 4'(clef_pkg::BCD_DIGITS - 1);
    localparam int                BW       = clef_pkg::BCD_WIDTH;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHAR = 3'd1;
    localparam logic [2:0] S_BL   = 3'd2;
    localparam logic [2:0] S_HEX  = 3'd3;
    localparam logic [2:0] S_CONV = 3'd4;
    localparam logic [2:0] S_SKIP = 3'd5;
    localparam logic [2:0] S_DEC  = 3'd6;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [3:0]        ctrl_reg;
    logic [3:0]        ctrl_next;
    logic [7:0]        addr_reg;
    logic              is_data_reg;
    logic              is_data_next;
    logic [31:0]       work_sh_reg;
    logic [31:0]       work_sh_next;
    logic [HEX_CW-1:0] hex_cnt_reg;
    logic [HEX_CW-1:0] hex_cnt_next;
    logic [BW-1:0]     dig_sh_reg;
    logic [BW-1:0]     dig_sh_next;
    logic [3:0]        dig_idx_reg;
    logic [3:0]        dig_idx_next;
    logic              dec_nz_reg;
    logic              dec_nz_next;

    logic              res_valid_reg;
    logic              res_valid_next;
    logic [7:0]        res_b_reg [7];
    logic [2:0]        res_count_reg;
    logic              res_last_reg;

    logic              out_free;
    logic              emit_go;
    logic              emit_bl;
    logic              emit_is_data;
    logic              emit_last;
    logic [7:0]        emit_ch;
    logic [3:0]        hex_digit;
    logic              hex_pad;
    logic [3:0]        ctrl_bl;
    clef_pkg::char_frame_t frame;

    logic                      bcd_start;
    clef_pkg::bcd_status_t     bcd_stat;
    logic [BW-1:0]             bcd_value;

    clef_bcd_conv u_bcd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bcd_start),
        .value  (work_sh_next),
        .status (bcd_stat),
        .bcd    (bcd_value)
    );

    assign out_free      = !res_valid_reg || result.ready;
    assign request.ready = (state_reg == S_IDLE);

    // Positions from bit 32 upwards are padding and print as zero.
    assign hex_pad   = (32'(hex_cnt_reg) >= 32'd8);
    assign hex_digit = hex_pad ? 4'h0 : work_sh_reg[31:28];

    always_comb
    begin
        state_next   = state_reg;
        is_data_next = is_data_reg;
        work_sh_next = work_sh_reg;
        hex_cnt_next = hex_cnt_reg;
        dig_sh_next  = dig_sh_reg;
        dig_idx_next = dig_idx_reg;
        dec_nz_next  = dec_nz_reg;
        bcd_start    = 1'b0;
        emit_go      = 1'b0;
        emit_bl      = 1'b0;
        emit_is_data = 1'b1;
        emit_last    = 1'b0;
        emit_ch      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    work_sh_next = request.value;
                    unique case (request.operation)
                        clef_pkg::OP_COMMAND, clef_pkg::OP_DATA:
                        begin
                            is_data_next = (request.operation == clef_pkg::OP_DATA);
                            state_next   = S_CHAR;
                        end
                        clef_pkg::OP_HEX:
                        begin
                            work_sh_next = request.value << HEX_PRE;
                            hex_cnt_next = HEX_TOP;
                            state_next   = S_HEX;
                        end
                        clef_pkg::OP_DECIMAL:
                        begin
                            bcd_start  = 1'b1;
                            state_next = S_CONV;
                        end
                        clef_pkg::OP_BACKLIGHT:
                        begin
                            state_next = S_BL;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHAR:
            begin
                if (out_free)
                begin
                    emit_go      = 1'b1;
                    emit_ch      = work_sh_reg[7:0];
                    emit_is_data = is_data_reg;
                    emit_last    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_BL:
            begin
                if (out_free)
                begin
                    emit_go    = 1'b1;
                    emit_bl    = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_HEX:
            begin
                if (out_free)
                begin
                    emit_go   = 1'b1;
                    emit_ch   = (hex_digit <= 4'd9) ? clef_pkg::CHAR_ZERO + {4'h0, hex_digit}
                                                    : clef_pkg::CHAR_HEX_BASE + {4'h0, hex_digit};
                    emit_last = (hex_cnt_reg == '0);
                    if (!hex_pad)
                    begin
                        work_sh_next = {work_sh_reg[27:0], 4'h0};
                    end
                    hex_cnt_next = hex_cnt_reg - HEX_CW'(1);
                    if (hex_cnt_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CONV:
            begin
                if (bcd_stat.done)
                begin
                    dig_sh_next  = bcd_value;
                    dig_idx_next = DIG_TOP;
                    dec_nz_next  = 1'b0;
                    state_next   = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Drop positions beyond the kept digits and leading zeros; the
                // units digit always prints, so zero comes out as '0'. Once a
                // non-zero digit has been dropped above the kept positions, the
                // value is longer than what is kept and every kept digit prints.
                if (({1'b0, dig_idx_reg} >= DEC_KEEP) ||
                    ((dig_sh_reg[BW-1 -: 4] == 4'h0) && (dig_idx_reg != 4'h0) &&
                     !dec_nz_reg))
                begin
                    dec_nz_next  = dec_nz_reg | (dig_sh_reg[BW-1 -: 4] != 4'h0);
                    dig_sh_next  = {dig_sh_reg[BW-5:0], 4'h0};
                    dig_idx_next = dig_idx_reg - 4'd1;
                end
                else
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (out_free)
                begin
                    emit_go      = 1'b1;
                    emit_ch      = clef_pkg::CHAR_ZERO + {4'h0, dig_sh_reg[BW-1 -: 4]};
                    emit_last    = (dig_idx_reg == 4'h0);
                    dig_sh_next  = {dig_sh_reg[BW-5:0], 4'h0};
                    dig_idx_next = dig_idx_reg - 4'd1;
                    if (dig_idx_reg == 4'h0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Byte building for the result register.
    assign frame   = clef_pkg::char_frame(ctrl_reg, emit_is_data, emit_ch);
    assign ctrl_bl = ctrl_reg | clef_pkg::CTRL_BL;

    always_comb
    begin
        ctrl_next      = ctrl_reg;
        res_valid_next = res_valid_reg;
        if (emit_go)
        begin
            ctrl_next      = emit_bl ? ctrl_bl : frame.ctrl;
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ctrl_reg      <= '0;
            addr_reg      <= 8'h4E;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctrl_reg      <= ctrl_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write_en)
            begin
                addr_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_data_reg <= is_data_next;
        work_sh_reg <= work_sh_next;
        hex_cnt_reg <= hex_cnt_next;
        dig_sh_reg  <= dig_sh_next;
        dig_idx_reg <= dig_idx_next;
        dec_nz_reg  <= dec_nz_next;
        if (emit_go)
        begin
            res_last_reg <= emit_last;
            if (emit_bl)
            begin
                res_b_reg[0]  <= {4'h0, ctrl_bl};
                res_b_reg[1]  <= '0;
                res_b_reg[2]  <= '0;
                res_b_reg[3]  <= '0;
                res_b_reg[4]  <= '0;
                res_b_reg[5]  <= '0;
                res_b_reg[6]  <= '0;
                res_count_reg <= clef_pkg::COUNT_BL;
            end
            else
            begin
                res_b_reg[0]  <= frame.b1;
                res_b_reg[1]  <= frame.b2;
                res_b_reg[2]  <= frame.b3;
                res_b_reg[3]  <= frame.b4;
                res_b_reg[4]  <= frame.b5;
                res_b_reg[5]  <= frame.b6;
                res_b_reg[6]  <= frame.b7;
                res_count_reg <= clef_pkg::COUNT_CHAR;
            end
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.byte_first     = res_b_reg[0];
    assign result.byte_second    = res_b_reg[1];
    assign result.byte_third     = res_b_reg[2];
    assign result.byte_fourth    = res_b_reg[3];
    assign result.byte_fifth     = res_b_reg[4];
    assign result.byte_sixth     = res_b_reg[5];
    assign result.byte_seventh   = res_b_reg[6];
    assign result.byte_count     = res_count_reg;
    assign result.last_of_run    = res_last_reg;
    assign result.device_address = addr_reg;

    // Between requests the enable strobe must always be left low.
    a_en_low_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (ctrl_reg[2] == 1'b0))
        else $error("EN bit left high between requests");

    // The converter only finishes while the sequencer waits for it.
    a_conv_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        bcd_stat.done |-> (state_reg == S_CONV))
        else $error("converter finished outside the conversion wait");

    // While the sequencer waits, the converter is either shifting or just finished.
    a_conv_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) |-> (bcd_stat.busy || bcd_stat.done))
        else $error("sequencer waiting on an idle converter");

    // The closing beat of a request returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && emit_last) |=> (state_reg == S_IDLE))
        else $error("sequencer still busy after the last beat");

    // A backlight beat carries one byte and nothing else.
    a_bl_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.byte_count == clef_pkg::COUNT_BL)) |->
        ((result.byte_second == 8'h00) && (result.byte_seventh == 8'h00) &&
         result.last_of_run))
        else $error("backlight beat malformed");

endmodule

// File: test/char_lcd_expander_formatter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the character LCD expander formatter: directed and random
// requests, each predicted beat by beat by an in-bench model of the expander byte stream.
// Depends on clef_pkg, clef_channels and the formatter RTL.
module char_lcd_expander_formatter_test;

    // Codes five to seven are not defined by the package; the block drops them.
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    localparam logic [7:0] ASCII_ZERO        = 8'h30;
    localparam logic [7:0] ASCII_LETTER_BASE = 8'h37;   // 'A' less ten
    localparam logic [7:0] ADDRESS_AT_RESET  = 8'h4E;

    localparam int HEX_CHARS       = 8;
    localparam int DEC_CHARS       = 10;
    localparam int SETTLE_CYCLES   = 60;     // long enough for a decimal print to finish
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_GAP         = 40;
    localparam int REPORT_LIMIT    = 10;

    // One result beat as the bus master sees it: the seven expander bytes in send order,
    // the count of valid bytes, the end-of-request flag and the address carried along.
    typedef struct packed {
        logic [0:6][7:0] lane;
        logic [2:0]      count;
        logic            last;
        logic [7:0]      addr;
    } expander_beat_t;

    // The scoreboard keeps its own copy of the control bits and of the device address,
    // turns every accepted request into the beats it must cause, and checks the beats
    // that leave the block against them in order.
    class lcd_beat_scoreboard;
        logic [3:0]     ctrl_bits;
        logic [7:0]     address;
        expander_beat_t beats_due[$];
        int             mismatches;

        function new();
            ctrl_bits  = 4'h0;
            address    = ADDRESS_AT_RESET;
            mismatches = 0;
        endfunction

        function int beats_owed();
            return beats_due.size();
        endfunction

        // One character in 4-bit mode: RS updated, then the high nibble strobed with EN,
        // then the low nibble. EN is left cleared, RS and the backlight stay as they are.
        function void render_char(logic [7:0] ch, logic is_data, logic last);
            expander_beat_t b;
            logic [3:0]     strobe;
            logic [3:0]     settle;
            ctrl_bits = is_data ? (ctrl_bits | clef_pkg::CTRL_RS)
                                : (ctrl_bits & ~clef_pkg::CTRL_RS);
            strobe    = ctrl_bits | clef_pkg::CTRL_EN;
            settle    = strobe & ~clef_pkg::CTRL_EN;
            b.lane    = {{4'h0, ctrl_bits}, {4'h0, strobe}, {ch[7:4], strobe},
                         {4'h0, settle}, {4'h0, strobe}, {ch[3:0], strobe}, {4'h0, settle}};
            b.count   = clef_pkg::COUNT_CHAR;
            b.last    = last;
            b.addr    = address;
            ctrl_bits = settle;
            beats_due.push_back(b);
        endfunction

        function void note_request(logic [2:0] op, logic [31:0] val);
            expander_beat_t b;
            logic [3:0]     nibble;
            logic [3:0]     digits[DEC_CHARS];
            int unsigned    rest;
            int             n;
            int             k;
            case (op)
                clef_pkg::OP_COMMAND, clef_pkg::OP_DATA:
                    render_char(val[7:0], op == clef_pkg::OP_DATA, 1'b1);
                clef_pkg::OP_HEX:
                begin
                    for (k = HEX_CHARS - 1; k >= 0; k--)
                    begin
                        nibble = val[4 * k +: 4];
                        render_char(nibble <= 4'd9 ? ASCII_ZERO + nibble
                                                   : ASCII_LETTER_BASE + nibble,
                                    1'b1, k == 0);
                    end
                end
                clef_pkg::OP_DECIMAL:
                begin
                    // Least significant digit first, then printed most significant first.
                    // A zero value still prints a single digit.
                    rest = val;
                    n    = 0;
                    while (rest != 0 && n < DEC_CHARS)
                    begin
                        digits[n] = 4'(rest % 10);
                        rest      = rest / 10;
                        n++;
                    end
                    if (n == 0)
                    begin
                        digits[0] = 4'd0;
                        n         = 1;
                    end
                    for (k = n - 1; k >= 0; k--)
                        render_char(ASCII_ZERO + digits[k], 1'b1, k == 0);
                end
                clef_pkg::OP_BACKLIGHT:
                begin
                    ctrl_bits = ctrl_bits | clef_pkg::CTRL_BL;
                    b.lane    = '0;
                    b.lane[0] = {4'h0, ctrl_bits};
                    b.count   = clef_pkg::COUNT_BL;
                    b.last    = 1'b1;
                    b.addr    = address;
                    beats_due.push_back(b);
                end
                default:
                    ;
            endcase
        endfunction

        function void check_beat(expander_beat_t got);
            expander_beat_t want;
            if (beats_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected beat: bytes %h count %0d last %0b addr %h",
                             got.lane, got.count, got.last, got.addr);
            end
            else
            begin
                want = beats_due.pop_front();
                if (got.lane !== want.lane || got.count !== want.count ||
                    got.last !== want.last || got.addr !== want.addr)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("beat mismatch: expected bytes %h count %0d last %0b addr %h",
                                 want.lane, want.count, want.last, want.addr);
                        $display("               got bytes %h count %0d last %0b addr %h",
                                 got.lane, got.count, got.last, got.addr);
                    end
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_en;
    logic [7:0]         cfg_write_data;
    logic               hold_active;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    event               hold_off_go;
    lcd_beat_scoreboard sb = new();

    clef_req_if req_ch();
    clef_res_if res_ch();

    char_lcd_expander_formatter dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .request        (req_ch),
        .result         (res_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #5 clk = ~clk;

    // Receiver. Every input of the block is driven with nonblocking assignments at the
    // rising edge, so the block and the monitor both see the values from before the edge.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The long hold-off is timed here, apart from the stimulus, so that the sender keeps
    // offering requests while the result register stays full and the block stops taking
    // new ones.
    initial
    begin
        hold_active <= 1'b0;
        forever
        begin
            @(hold_off_go);
            hold_active <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // Every result beat taken by the receiver is checked against the oldest prediction.
    always @(posedge clk)
    begin
        expander_beat_t seen;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen = {res_ch.byte_first, res_ch.byte_second, res_ch.byte_third,
                    res_ch.byte_fourth, res_ch.byte_fifth, res_ch.byte_sixth,
                    res_ch.byte_seventh, res_ch.byte_count, res_ch.last_of_run,
                    res_ch.device_address};
            sb.check_beat(seen);
        end
    end

    // Offers one request after a random gap and returns at the edge where it is taken.
    // Valid is left high, so back-to-back requests need no second assignment in the step.
    task automatic send_request(input logic [2:0] op, input logic [31:0] val);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(op, val);
    endtask

    // Stops offering until every predicted beat has arrived, then waits out any dropped
    // request or conversion still under way, so that the block is idle afterwards.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.beats_owed() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_address(input logic [7:0] addr);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= addr;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.address = addr;
    endtask

    // Values lean towards the awkward ones for decimal printing: short numbers, powers of
    // ten and one below them, and the two extremes, besides fully random words.
    function automatic logic [31:0] random_value();
        int unsigned p;
        int          k;
        logic [31:0] v;
        case ($urandom_range(5))
            0:
                v = $urandom_range(99);
            1:
                v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            2:
            begin
                p = 1;
                k = $urandom_range(9);
                repeat (k) p = p * 10;
                v = p - $urandom_range(1);
            end
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] random_op();
        logic [2:0] op;
        if ($urandom_range(99) < 5)
            op = OP_RESERVED_LO + 3'($urandom_range(2));
        else
            op = 3'($urandom_range(4));
        return op;
    endfunction

    // Dropped codes do not count towards the number of requests.
    task automatic run_random(input int count);
        logic [2:0] op;
        int         taken;
        taken = 0;
        while (taken < count)
        begin
            op = random_op();
            send_request(op, random_value());
            if (op <= clef_pkg::OP_BACKLIGHT)
                taken++;
            if ($urandom_range(59) == 0)
                drain_results();
        end
    endtask

    task automatic run_directed();
        send_request(clef_pkg::OP_COMMAND, 32'h0000_0000);
        send_request(clef_pkg::OP_COMMAND, 32'h0000_00FF);
        send_request(clef_pkg::OP_DATA, 32'h0000_0000);
        // Only the low byte of a character counts.
        send_request(clef_pkg::OP_DATA, 32'hFFFF_FF5A);
        send_request(clef_pkg::OP_DATA, 32'h0000_00FF);
        send_request(clef_pkg::OP_HEX, 32'h0000_0000);
        send_request(clef_pkg::OP_HEX, 32'hFFFF_FFFF);
        send_request(clef_pkg::OP_HEX, 32'h0123_4567);
        send_request(clef_pkg::OP_HEX, 32'h89AB_CDEF);
        // Zero must print one digit; the largest value fills all ten positions.
        send_request(clef_pkg::OP_DECIMAL, 32'd0);
        send_request(clef_pkg::OP_DECIMAL, 32'd1);
        send_request(clef_pkg::OP_DECIMAL, 32'd9);
        send_request(clef_pkg::OP_DECIMAL, 32'd10);
        send_request(clef_pkg::OP_DECIMAL, 32'd4294967295);
        send_request(clef_pkg::OP_DECIMAL, 32'd1000000000);
        send_request(clef_pkg::OP_DECIMAL, 32'd999999999);
        send_request(OP_RESERVED_LO, 32'hFFFF_FFFF);
        send_request(OP_RESERVED_LO + 3'd1, 32'h0000_0000);
        send_request(OP_RESERVED_HI, 32'h1234_5678);
        // The backlight bit must stay set through the characters that follow.
        send_request(clef_pkg::OP_BACKLIGHT, 32'hFFFF_FFFF);
        send_request(clef_pkg::OP_COMMAND, 32'h0000_0028);
        send_request(clef_pkg::OP_BACKLIGHT, 32'h0000_0000);
        send_request(clef_pkg::OP_DATA, 32'h0000_0041);
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_write_en     <= 1'b0;
        cfg_write_data   <= 8'h00;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= clef_pkg::OP_COMMAND;
        req_ch.value     <= 32'h0;
        send_idle_pct     = 34;
        recv_idle_pct    <= 87;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset address is checked by the directed part before any write.
        run_directed();
        drain_results();
        write_address(8'h00);
        run_random(90);
        drain_results();

        write_address(8'hFF);
        send_idle_pct  = 87;
        recv_idle_pct <= 34;
        run_random(90);
        drain_results();

        // No idling at all; the hold-off starts with the first requests of this phase.
        write_address(8'($urandom_range(255)));
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        -> hold_off_go;
        run_random(10);
        run_random(85);
        drain_results();

        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
